FILE: sv/spt_pkg.sv
// Shared constants, control structs and sizes for the seeded permutation table.
// Depends on nothing; the interfaces, spt_lcg, spt_mod_unit and the top level import it.
package spt_pkg;

   // Largest permutation the table holds.
   localparam int MAX_BLOCKS = 4096;

   // Table address and entry width, and the width of a count of 0..MAX_BLOCKS.
   localparam int ADDR_W = $clog2(MAX_BLOCKS);
   localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);

   // Request and response field widths.
   localparam int COUNT_W = 13;
   localparam int POS_W   = 12;
   localparam int NUM_W   = 12;
   localparam int SEED_W  = 32;

   // Generator constants.
   localparam logic [SEED_W-1:0] SEED_RESET = 32'hDEADBEEF;
   localparam logic [SEED_W-1:0] LCG_MUL    = 32'd1664525;
   localparam logic [SEED_W-1:0] LCG_ADD    = 32'd1013904223;

   // The remainder unit works on the generator state shifted right by one.
   localparam int DVD_W  = SEED_W - 1;
   localparam int STEP_W = $clog2(DVD_W + 1);

   typedef struct packed {
      logic              start;
      logic [DVD_W-1:0]  dividend;
      logic [CNT_W-1:0]  divisor;
   } mod_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [ADDR_W-1:0] remainder;
   } mod_rsp_type;

   typedef struct packed {
      logic load;
      logic step;
   } lcg_ctrl_type;

endpackage

FILE: sv/spt_req_if.sv
// Request channel of the seeded permutation table: valid, ready and the lookup fields.
// Depends on spt_pkg for the field widths.
interface spt_req_if;
   import spt_pkg::*;

   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] block_count;
   logic [POS_W-1:0]   position;

   modport source (output valid, output block_count, output position, input ready);
   modport sink   (input valid, input block_count, input position, output ready);
endinterface

FILE: sv/spt_rsp_if.sv
// Response channel of the seeded permutation table: valid, ready and the result fields.
// Depends on spt_pkg for the field widths.
interface spt_rsp_if;
   import spt_pkg::*;

   logic             valid;
   logic             ready;
   logic [NUM_W-1:0] block_number;
   logic             in_range;

   modport source (output valid, output block_number, output in_range, input ready);
   modport sink   (input valid, input block_number, input in_range, output ready);
endinterface

FILE: sv/spt_csr_if.sv
// Register write channel of the seeded permutation table: valid, ready and the seed.
// Depends on spt_pkg for the seed width.
interface spt_csr_if;
   import spt_pkg::*;

   logic              valid;
   logic              ready;
   logic [SEED_W-1:0] shuffle_seed;

   modport source (output valid, output shuffle_seed, input ready);
   modport sink   (input valid, input shuffle_seed, output ready);
endinterface

FILE: sv/spt_ram.sv
// Generic memory with one write port and one registered read port.
// Depends on nothing.
module spt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // The read register holds its value until the next read.
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/spt_lcg.sv
// Linear congruential generator used to draw the swap index of each shuffle step.
// Depends on spt_pkg for the constants and the control struct.
module spt_lcg (
   input  logic                      clock,
   input  logic [spt_pkg::SEED_W-1:0] seed,
   input  spt_pkg::lcg_ctrl_type      ctrl,
   output logic [spt_pkg::SEED_W-1:0] state
);
   import spt_pkg::*;

   logic [SEED_W-1:0] x_ff;
   logic [SEED_W-1:0] x_in;

   always_comb begin
      x_in = x_ff;
      if (ctrl.load) begin
         x_in = seed;
      end else if (ctrl.step) begin
         // Arithmetic wraps modulo 2^32.
         x_in = x_ff * LCG_MUL + LCG_ADD;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
   end

   assign state = x_ff;

endmodule

FILE: sv/spt_mod_unit.sv
// Bit-serial restoring remainder unit: one dividend bit per cycle, one compare and subtract.
// Depends on spt_pkg for the widths and the request and response structs.
module spt_mod_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  spt_pkg::mod_req_type mod_req,
   output spt_pkg::mod_rsp_type mod_rsp
);
   import spt_pkg::*;

   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [CNT_W-1:0]  div_ff, div_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W:0]    trial;

   always_comb begin
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, dvd_ff[DVD_W-1]};

      if (mod_req.start) begin
         rem_in  = '0;
         dvd_in  = mod_req.dividend;
         div_in  = mod_req.divisor;
         cnt_in  = STEP_W'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // The partial remainder stays below the divisor, so one subtract suffices.
         if (trial >= {1'b0, div_ff}) begin
            rem_in = CNT_W'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[CNT_W-1:0];
         end
         dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      div_ff <= div_in;
   end

   assign mod_rsp.busy      = busy_ff;
   assign mod_rsp.done      = done_ff;
   assign mod_rsp.remainder = rem_ff[ADDR_W-1:0];

endmodule

FILE: sv/seeded_permutation_table.sv
// Top level of the seeded permutation table: sequencer, seed register and response register.
// Depends on spt_pkg, the three channel interfaces, spt_ram, spt_lcg and spt_mod_unit.
//
//   Channel   Direction  Payload                     Completes when
//   req_ch    in         block_count, position       valid and ready high at a clock edge
//   rsp_ch    out        block_number, in_range      valid and ready high at a clock edge
//   csr_ch    in         shuffle_seed                valid and ready high at a clock edge
//
// A request whose saturated count is zero or matches the count the table was built for
// reads the table at the accepting edge and then loads the response register.
// A request with a new nonzero count first rebuilds the table: an identity fill of count
// entries, then count-1 shuffle steps, each bound by the bit-serial remainder unit.
// Reset is synchronous and active high; it clears the sequencer and the built count, sets
// the seed register to SEED_RESET, and leaves the table contents undefined.
// The response register decouples the sides: a stalled response holds only the final
// load, so the sequencer waits in its last state until the previous response is taken.
module seeded_permutation_table (
   input logic      clock,
   input logic      reset,
   spt_req_if.sink   req_ch,
   spt_rsp_if.source rsp_ch,
   spt_csr_if.sink   csr_ch
);
   import spt_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FILL,
      ST_ADVANCE,
      ST_MOD_START,
      ST_MOD_WAIT,
      ST_SWAP_TOP,
      ST_SWAP_J,
      ST_LOOK_READ,
      ST_LOOK_DATA
   } state_type;

   state_type         state_ff, state_in;
   logic [SEED_W-1:0] seed_ff, seed_in;
   logic [CNT_W-1:0]  built_ff, built_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              range_ff, range_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [ADDR_W-1:0] top_ff, top_in;
   logic [ADDR_W-1:0] j_ff, j_in;
   logic [ADDR_W-1:0] hold_ff, hold_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [NUM_W-1:0]  rsp_num_ff, rsp_num_in;
   logic              rsp_range_ff, rsp_range_in;

   logic [CNT_W-1:0]  count_sat;
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [ADDR_W-1:0] ram_wdata;
   logic              ram_re;
   logic [ADDR_W-1:0] ram_raddr;
   logic [ADDR_W-1:0] ram_rdata;
   lcg_ctrl_type      lcg_ctrl;
   logic [SEED_W-1:0] lcg_x;
   mod_req_type       mod_req;
   mod_rsp_type       mod_rsp;

   // The permutation table.
   spt_ram #(
      .WIDTH (ADDR_W),
      .DEPTH (MAX_BLOCKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   spt_lcg u_lcg (
      .clock (clock),
      .seed  (seed_ff),
      .ctrl  (lcg_ctrl),
      .state (lcg_x)
   );

   spt_mod_unit u_mod (
      .clock   (clock),
      .reset   (reset),
      .mod_req (mod_req),
      .mod_rsp (mod_rsp)
   );

   // Counts above the table size are treated as the full table.
   always_comb begin
      if (32'(req_ch.block_count) > 32'(MAX_BLOCKS)) begin
         count_sat = CNT_W'(MAX_BLOCKS);
      end else begin
         count_sat = CNT_W'(req_ch.block_count);
      end
   end

   always_comb begin
      state_in     = state_ff;
      seed_in      = seed_ff;
      built_in     = built_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      range_in     = range_ff;
      idx_in       = idx_ff;
      top_in       = top_ff;
      j_in         = j_ff;
      hold_in      = hold_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_num_in   = rsp_num_ff;
      rsp_range_in = rsp_range_ff;

      ram_we    = 1'b0;
      ram_waddr = '0;
      ram_wdata = '0;
      ram_re    = 1'b0;
      ram_raddr = '0;
      lcg_ctrl  = '0;
      mod_req   = '0;

      // A response that is taken frees the response register.
      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               pos_in   = req_ch.position;
               count_in = count_sat;
               range_in = 32'(req_ch.position) < 32'(count_sat);
               if (count_sat != built_ff && count_sat != '0) begin
                  // New count: restart the generator and fill with the identity.
                  built_in      = count_sat;
                  lcg_ctrl.load = 1'b1;
                  idx_in        = '0;
                  state_in      = ST_FILL;
               end else begin
                  // Table is current (or the count is zero): read at once.
                  built_in  = count_sat;
                  ram_re    = 1'b1;
                  ram_raddr = ADDR_W'(req_ch.position);
                  state_in  = ST_LOOK_DATA;
               end
            end
         end

         ST_FILL: begin
            ram_we    = 1'b1;
            ram_waddr = idx_ff[ADDR_W-1:0];
            ram_wdata = idx_ff[ADDR_W-1:0];
            idx_in    = idx_ff + 1'b1;
            if (idx_ff == count_ff - 1'b1) begin
               if (count_ff == CNT_W'(1)) begin
                  state_in = ST_LOOK_READ;
               end else begin
                  top_in   = ADDR_W'(count_ff - 1'b1);
                  state_in = ST_ADVANCE;
               end
            end
         end

         ST_ADVANCE: begin
            // Advance the generator and fetch the entry at the top index.
            lcg_ctrl.step = 1'b1;
            ram_re        = 1'b1;
            ram_raddr     = top_ff;
            state_in      = ST_MOD_START;
         end

         ST_MOD_START: begin
            hold_in          = ram_rdata;
            mod_req.start    = 1'b1;
            mod_req.dividend = lcg_x[SEED_W-1:1];
            mod_req.divisor  = CNT_W'(top_ff) + CNT_W'(1);
            state_in         = ST_MOD_WAIT;
         end

         ST_MOD_WAIT: begin
            if (mod_rsp.done) begin
               ram_re    = 1'b1;
               ram_raddr = mod_rsp.remainder;
               j_in      = mod_rsp.remainder;
               state_in  = ST_SWAP_TOP;
            end
         end

         ST_SWAP_TOP: begin
            ram_we    = 1'b1;
            ram_waddr = top_ff;
            ram_wdata = ram_rdata;
            state_in  = ST_SWAP_J;
         end

         ST_SWAP_J: begin
            ram_we    = 1'b1;
            ram_waddr = j_ff;
            ram_wdata = hold_ff;
            if (top_ff == ADDR_W'(1)) begin
               state_in = ST_LOOK_READ;
            end else begin
               top_in   = top_ff - 1'b1;
               state_in = ST_ADVANCE;
            end
         end

         ST_LOOK_READ: begin
            ram_re    = 1'b1;
            ram_raddr = ADDR_W'(pos_ff);
            state_in  = ST_LOOK_DATA;
         end

         ST_LOOK_DATA: begin
            // The read register holds its data while the response side stalls.
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_num_in   = range_ff ? NUM_W'(ram_rdata) : '0;
               rsp_range_in = range_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A new seed invalidates the table so that the next request with a nonzero count rebuilds it.
      if (csr_ch.valid) begin
         seed_in  = csr_ch.shuffle_seed;
         built_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seed_ff      <= SEED_RESET;
         built_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seed_ff      <= seed_in;
         built_ff     <= built_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      count_ff     <= count_in;
      pos_ff       <= pos_in;
      range_ff     <= range_in;
      idx_ff       <= idx_in;
      top_ff       <= top_in;
      j_ff         <= j_in;
      hold_ff      <= hold_in;
      rsp_num_ff   <= rsp_num_in;
      rsp_range_ff <= rsp_range_in;
   end

   assign req_ch.ready        = (state_ff == ST_IDLE);
   assign csr_ch.ready        = 1'b1;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.block_number = rsp_num_ff;
   assign rsp_ch.in_range     = rsp_range_ff;

`ifndef SYNTHESIS
   // An out-of-range response always carries block number zero.
   a_out_of_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.in_range |-> rsp_ch.block_number == '0)
      else $error("out-of-range response with nonzero block number");

   // Every table write during a rebuild lands below the count being built.
   a_write_in_bounds: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> CNT_W'(ram_waddr) < count_ff)
      else $error("table write outside the current count");

   // The remainder unit is never restarted while it is still working.
   a_mod_no_restart: assert property (@(posedge clock) disable iff (reset)
      mod_req.start |-> !mod_rsp.busy)
      else $error("remainder unit started while busy");

   // An accepted request blocks further requests in the following cycle.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("request accepted in back-to-back cycles");
`endif

endmodule
